// File: rtl/ttp_pkg.sv
// shared types, constants and coefficient table of the transition row generator
`default_nettype none
package ttp_pkg;

    localparam int DIV_NW = 66;
    localparam int DIV_DW = 50;
    localparam int DIV_QW = 21;
    localparam int DIV_TW = 5;

    localparam logic [12:0] SNR_CAP    = 13'd5120;
    localparam logic [12:0] SNR_CAP_C  = 13'd4864;
    localparam logic [1:0]  BASE_C     = 2'd1;
    localparam logic [30:0] LOG2E_Q30  = 31'd1549082005;
    localparam logic [29:0] LN2_Q30    = 30'd744261118;
    localparam logic [27:0] X_DIVISOR  = 28'd244140625;
    // floor(2^61 / X_DIVISOR)
    localparam logic [34:0] X_RECIP    = 35'd9444732965;
    localparam logic signed [49:0] CLAMP_X = 50'sd16000000000000;

    typedef struct packed {
        logic [1:0] base_code;
        logic       is_last;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  position_base;
        logic [15:0] match_prob;
        logic [15:0] branch_prob;
        logic [15:0] stick_prob;
        logic [15:0] deletion_prob;
        logic        row_last;
    } t_row;

    // ceil(2^34 / n): exact floor division by n for values below 2^31
    function automatic logic [34:0] recip_m(input logic [3:0] n);
        logic [34:0] m;
        case (n)
            4'd1:    m = 35'd17179869184;
            4'd2:    m = 35'd8589934592;
            4'd3:    m = 35'd5726623062;
            4'd4:    m = 35'd4294967296;
            4'd5:    m = 35'd3435973837;
            4'd6:    m = 35'd2863311531;
            4'd7:    m = 35'd2454267027;
            4'd8:    m = 35'd2147483648;
            default: m = 35'd0;
        endcase
        return m;
    endfunction

    // coefficient in units of 1e-12, by base, repeat flag, polynomial and power
    function automatic logic signed [43:0] coef_at(input logic [1:0] curr, input logic rep,
                                                   input logic [1:0] j, input logic [1:0] p);
        logic [6:0] r3;
        logic [6:0] idx;
        logic signed [43:0] c;
        r3  = 7'({curr, rep}) * 7'd3 + 7'(j);
        idx = {r3[4:0], p};
        case (idx)
            7'd0:  c = 44'sd2359360608956;
            7'd1:  c = -44'sd463630601682;
            7'd2:  c = 44'sd17920689776;
            7'd3:  c = -44'sd230839937;
            7'd4:  c = 44'sd3228478306258;
            7'd5:  c = -44'sd88682021493;
            7'd6:  c = 44'sd5559817127;
            7'd7:  c = -44'sd137686231;
            7'd8:  c = -44'sd101031042923;
            7'd9:  c = -44'sd13878376783;
            7'd10: c = -44'sd1534080195;
            7'd11: c = 44'sd7667803;
            7'd12: c = 44'sd3761224806675;
            7'd13: c = -44'sd536010820176;
            7'd14: c = 44'sd27537505938;
            7'd15: c = -44'sd470200724;
            7'd16: c = 44'sd3575177253585;
            7'd17: c = -44'sd25754529537;
            7'd18: c = -44'sd163673803;
            7'd19: c = 44'sd5325698;
            7'd20: c = 44'sd858421613302;
            7'd21: c = -44'sd27665421684;
            7'd22: c = -44'sd88554976;
            7'd23: c = -44'sd48535590;
            7'd24: c = 44'sd5956054206161;
            7'd25: c = -44'sd1718864708116;
            7'd26: c = 44'sd153315470604;
            7'd27: c = -44'sd4744885955;
            7'd28: c = 44'sd3894184644162;
            7'd29: c = -44'sd174182841558;
            7'd30: c = 44'sd17171929027;
            7'd31: c = -44'sd653629721;
            7'd32: c = 44'sd2405328870708;
            7'd33: c = -44'sd652606650098;
            7'd34: c = 44'sd68878386411;
            7'd35: c = -44'sd2464794946;
            7'd36: c = 44'sd5667255386747;
            7'd37: c = -44'sd1104621969339;
            7'd38: c = 44'sd87981109390;
            7'd39: c = -44'sd2593938008;
            7'd40: c = 44'sd4116827567670;
            7'd41: c = -44'sd124758322644;
            7'd42: c = 44'sd6597951779;
            7'd43: c = -44'sd361914629;
            7'd44: c = 44'sd3171038185074;
            7'd45: c = -44'sd729020290806;
            7'd46: c = 44'sd74978469039;
            7'd47: c = -44'sd2627795174;
            7'd48: c = 44'sd3535083046305;
            7'd49: c = -44'sd788027301381;
            7'd50: c = 44'sd46936780341;
            7'd51: c = -44'sd1062219247;
            7'd52: c = 44'sd2854401842222;
            7'd53: c = 44'sd166346531056;
            7'd54: c = -44'sd16616182815;
            7'd55: c = 44'sd439492705;
            7'd56: c = 44'sd238188180807;
            7'd57: c = 44'sd58944352288;
            7'd58: c = -44'sd12340104595;
            7'd59: c = 44'sd336854126;
            7'd60: c = 44'sd3819207787030;
            7'd61: c = -44'sd540309003502;
            7'd62: c = 44'sd38956926489;
            7'd63: c = -44'sd901245733;
            7'd64: c = 44'sd3313222161457;
            7'd65: c = 44'sd123514009118;
            7'd66: c = -44'sd8074014066;
            7'd67: c = 44'sd230843924;
            7'd68: c = 44'sd2060068775205;
            7'd69: c = -44'sd451486652688;
            7'd70: c = 44'sd37521289817;
            7'd71: c = -44'sd937676250;
            7'd72: c = 44'sd5361992806813;
            7'd73: c = -44'sd1460999089855;
            7'd74: c = 44'sd126755291030;
            7'd75: c = -44'sd3910273446;
            7'd76: c = 44'sd3415971431030;
            7'd77: c = -44'sd66984162951;
            7'd78: c = 44'sd13894487778;
            7'd79: c = -44'sd558939998;
            7'd80: c = 44'sd1373713767948;
            7'd81: c = -44'sd246963827944;
            7'd82: c = 44'sd20967423134;
            7'd83: c = -44'sd684856715;
            7'd84: c = 44'sd5393083682367;
            7'd85: c = -44'sd1329315680572;
            7'd86: c = 44'sd107844580241;
            7'd87: c = -44'sd3164629034;
            7'd88: c = 44'sd4210314049560;
            7'd89: c = -44'sd347546363361;
            7'd90: c = 44'sd29383917930;
            7'd91: c = -44'sd893802212;
            7'd92: c = 44'sd2331438898513;
            7'd93: c = -44'sd586068444099;
            7'd94: c = 44'sd40044954697;
            7'd95: c = -44'sd957298861;
            default: c = 44'sd0;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// File: rtl/ttp_mul.sv
// shared signed multiplier with registered product
`default_nettype none
module ttp_mul (
    input  wire                 i_clk,
    input  wire                 i_en,
    input  wire  signed [35:0]  i_a,
    input  wire  signed [35:0]  i_b,
    output logic signed [71:0]  o_p
);
    logic signed [71:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= i_a * i_b;
        end
    end

    assign o_p = r_p;
endmodule
`default_nettype wire

// File: rtl/ttp_div.sv
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none
module ttp_div (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_start,
    input  wire  [ttp_pkg::DIV_NW-1:0]     i_dividend,
    input  wire  [ttp_pkg::DIV_DW-1:0]     i_divisor,
    input  wire  [ttp_pkg::DIV_TW-1:0]     i_top,
    output logic                           o_done,
    output logic [ttp_pkg::DIV_QW-1:0]     o_quot
);
    import ttp_pkg::*;

    logic [DIV_NW-1:0] r_rem;
    logic [DIV_NW-1:0] r_den;
    logic [DIV_QW-1:0] r_q;
    logic [DIV_TW-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic              w_ge;

    assign w_ge = (r_rem >= r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= i_dividend;
                r_den  <= {{(DIV_NW-DIV_DW){1'b0}}, i_divisor} << i_top;
                r_q    <= '0;
                r_cnt  <= i_top;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (w_ge) begin
                    r_rem <= r_rem - r_den;
                end
                r_q   <= {r_q[DIV_QW-2:0], w_ge};
                r_den <= r_den >> 1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule
`default_nettype wire

// File: rtl/template_transition_probabilities.sv
// top level: sequencer, snr registers and output register of the transition row generator
// One template base is taken per beat. A base that follows another one produces
// a row of match, branch, stick and deletion probabilities for the previous
// position; the final base adds a terminal row. The block takes no new base
// while a row is in work. One shared 36x36 multiplier runs the three Horner
// polynomials, the Q.16 conversion by reciprocal multiplication and the
// exponential series step by step, and a bit-serial divider that yields one
// quotient bit per cycle performs the four normalizations. A base that emits
// no ordinary row bypasses the multiplier and the divider.
`default_nettype none
module template_transition_probabilities (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  ttp_pkg::t_in_beat i_in_beat,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output ttp_pkg::t_row     o_out_beat,
    input  wire               i_cfg_we,
    input  wire  [1:0]        i_cfg_idx,
    input  wire  [12:0]       i_cfg_data
);
    import ttp_pkg::*;

    typedef enum logic [18:0] {
        S_IDLE   = 19'h00001,
        S_HLO    = 19'h00002,
        S_HHI    = 19'h00004,
        S_HADD   = 19'h00008,
        S_CLAMP  = 19'h00010,
        S_XDIV   = 19'h00020,
        S_YMUL   = 19'h00040,
        S_YSET   = 19'h00080,
        S_TMUL   = 19'h00100,
        S_TSET   = 19'h00200,
        S_SMUL   = 19'h00400,
        S_SDIV   = 19'h00800,
        S_SACC   = 19'h01000,
        S_ESET   = 19'h02000,
        S_QSTART = 19'h04000,
        S_QWAIT  = 19'h08000,
        S_ROW    = 19'h10000,
        S_TERM   = 19'h20000,
        S_XFIX   = 19'h40000
    } t_state;

    localparam logic [DIV_NW-1:0] BRANCH_NUM = {{(DIV_NW-40){1'b0}}, 1'b1, 39'd0};

    t_state n_state, r_state;

    logic [12:0]        r_snr [4];
    logic [1:0]         r_prev;
    logic               r_have;
    logic [1:0]         r_curr;
    logic               r_rep;
    logic [1:0]         r_pos;
    logic               r_last;
    logic [12:0]        r_s;
    logic [1:0]         r_j;
    logic [1:0]         r_p;
    logic [3:0]         r_n;
    logic [1:0]         r_qi;
    logic signed [49:0] r_acc;
    logic [36:0]        r_plo;
    logic               r_neg;
    logic [20:0]        r_xq;
    logic signed [21:0] r_x;
    logic signed [6:0]  r_k;
    logic [15:0]        r_f;
    logic [29:0]        r_t;
    logic [30:0]        r_term;
    logic [30:0]        r_sum;
    logic [47:0]        r_e [3];
    logic [49:0]        r_ssum;
    logic [15:0]        r_q [4];
    logic               r_out_valid;
    t_row               r_out;

    logic               w_in_acc;
    logic               w_out_free;
    logic               w_out_load;
    logic [12:0]        w_snr_raw;
    logic [12:0]        w_snr_cap;
    logic [1:0]         w_c_curr;
    logic               w_c_rep;
    logic [1:0]         w_c_j;
    logic [1:0]         w_c_p;
    logic signed [43:0] w_coef;
    logic signed [35:0] w_ma;
    logic signed [35:0] w_mb;
    logic               w_men;
    logic signed [71:0] w_prod;
    logic [25:0]        w_acc_hi;
    logic signed [65:0] w_hsum;
    logic signed [49:0] w_accc;
    logic signed [49:0] w_abs;
    logic [48:0]        w_xrem;
    logic [20:0]        w_xq;
    logic [30:0]        w_sterm;
    logic signed [7:0]  w_sh;
    logic [7:0]         w_nsh;
    logic [47:0]        w_e;
    logic               w_dstart;
    logic [DIV_NW-1:0]  w_dnum;
    logic [DIV_DW-1:0]  w_dden;
    logic [DIV_TW-1:0]  w_dtop;
    logic               w_ddone;
    logic [DIV_QW-1:0]  w_dq;
    logic [DIV_NW-1:0]  w_half;
    logic [47:0]        w_qe;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_out_load  = (r_state inside {S_ROW, S_TERM}) && w_out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    // snr of the incoming base, clamped
    assign w_snr_raw = r_snr[i_in_beat.base_code];
    assign w_snr_cap = (i_in_beat.base_code == BASE_C) ? SNR_CAP_C : SNR_CAP;

    // coefficient table address
    always_comb begin
        w_c_curr = r_curr;
        w_c_rep  = r_rep;
        w_c_j    = r_j;
        w_c_p    = r_p - 2'd1;
        case (r_state)
            S_IDLE: begin
                w_c_curr = i_in_beat.base_code;
                w_c_rep  = (r_prev == i_in_beat.base_code);
                w_c_j    = 2'd0;
                w_c_p    = 2'd3;
            end
            S_ESET: begin
                w_c_j = r_j + 2'd1;
                w_c_p = 2'd3;
            end
            default: begin
            end
        endcase
    end

    assign w_coef   = coef_at(w_c_curr, w_c_rep, w_c_j, w_c_p);
    assign w_acc_hi = r_acc[49:24];

    // multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_HLO: begin
                w_ma = {12'd0, r_acc[23:0]};
                w_mb = {23'd0, r_s};
            end
            S_HHI: begin
                w_ma = {{10{w_acc_hi[25]}}, w_acc_hi};
                w_mb = {23'd0, r_s};
            end
            S_CLAMP: begin
                w_ma = {1'b0, w_abs[43:9]};
                w_mb = {1'b0, X_RECIP};
            end
            S_XDIV: begin
                w_ma = {15'd0, w_prod[68:48]};
                w_mb = {8'd0, X_DIVISOR};
            end
            S_YMUL: begin
                w_ma = {{14{r_x[21]}}, r_x};
                w_mb = {5'd0, LOG2E_Q30};
            end
            S_TMUL: begin
                w_ma = {20'd0, r_f};
                w_mb = {6'd0, LN2_Q30};
            end
            S_SMUL: begin
                w_ma = {5'd0, r_term};
                w_mb = {6'd0, r_t};
            end
            S_SDIV: begin
                w_ma = {5'd0, w_prod[60:30]};
                w_mb = {1'b0, recip_m(r_n)};
            end
            default: begin
            end
        endcase
    end

    assign w_men = r_state inside {S_HLO, S_HHI, S_CLAMP, S_XDIV, S_YMUL, S_TMUL, S_SMUL,
                                   S_SDIV};

    ttp_mul u_mul (
        .i_clk (i_clk),
        .i_en  (w_men),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_prod)
    );

    // horner step, clamp and exponent shift
    assign w_hsum  = $signed({w_prod[41:0], 24'd0}) + $signed({29'd0, r_plo});
    assign w_accc  = (r_acc > CLAMP_X) ? CLAMP_X : ((r_acc < -CLAMP_X) ? -CLAMP_X : r_acc);
    assign w_abs   = (w_accc < 0) ? -w_accc : w_accc;
    // q.16 conversion: estimate is low by at most one
    assign w_xrem  = {1'b0, w_abs[43:0], 4'd0} - w_prod[48:0];
    assign w_xq    = r_xq + {20'd0, (w_xrem >= {21'd0, X_DIVISOR})};
    assign w_sterm = w_prod[64:34];
    assign w_sh    = {r_k[6], r_k} - 8'sd6;
    assign w_nsh   = 8'(-w_sh);
    assign w_e     = (w_sh >= 0) ? ({17'd0, r_sum} << w_sh[4:0])
                                 : ({17'd0, r_sum} >> w_nsh[4:0]);

    // divider operands
    assign w_half = {{(DIV_NW-49){1'b0}}, r_ssum[49:1]};
    always_comb begin
        case (r_qi)
            2'd0:    w_qe = r_e[1];
            2'd2:    w_qe = r_e[2];
            default: w_qe = r_e[0];
        endcase
    end

    always_comb begin
        w_dstart = 1'b0;
        w_dnum   = '0;
        w_dden   = r_ssum;
        w_dtop   = DIV_TW'(15);
        case (r_state)
            S_QSTART: begin
                w_dstart = 1'b1;
                if (r_qi == 2'd1) begin
                    w_dnum = BRANCH_NUM + w_half;
                end else begin
                    w_dnum = {3'd0, w_qe, 15'd0} + w_half;
                end
            end
            default: begin
            end
        endcase
    end

    ttp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_dstart),
        .i_dividend (w_dnum),
        .i_divisor  (w_dden),
        .i_top      (w_dtop),
        .o_done     (w_ddone),
        .o_quot     (w_dq)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (r_have) begin
                        n_state = S_HLO;
                    end else if (i_in_beat.is_last) begin
                        n_state = S_TERM;
                    end
                end
            end
            S_HLO:   n_state = S_HHI;
            S_HHI:   n_state = S_HADD;
            S_HADD:  n_state = (r_p == 2'd1) ? S_CLAMP : S_HLO;
            S_CLAMP: n_state = S_XDIV;
            S_XDIV:  n_state = S_XFIX;
            S_XFIX:  n_state = S_YMUL;
            S_YMUL:  n_state = S_YSET;
            S_YSET:  n_state = S_TMUL;
            S_TMUL:  n_state = S_TSET;
            S_TSET:  n_state = S_SMUL;
            S_SMUL:  n_state = S_SDIV;
            S_SDIV:  n_state = S_SACC;
            S_SACC:  n_state = (r_n == 4'd8) ? S_ESET : S_SMUL;
            S_ESET:  n_state = (r_j == 2'd2) ? S_QSTART : S_HLO;
            S_QSTART: n_state = S_QWAIT;
            S_QWAIT: begin
                if (w_ddone) begin
                    n_state = (r_qi == 2'd3) ? S_ROW : S_QSTART;
                end
            end
            S_ROW: begin
                if (w_out_free) begin
                    n_state = r_last ? S_TERM : S_IDLE;
                end
            end
            S_TERM: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_snr[0]    <= '0;
            r_snr[1]    <= '0;
            r_snr[2]    <= '0;
            r_snr[3]    <= '0;
            r_prev      <= '0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_snr[i_cfg_idx] <= i_cfg_data;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_curr <= i_in_beat.base_code;
                        r_rep  <= (r_prev == i_in_beat.base_code);
                        r_pos  <= r_prev;
                        r_last <= i_in_beat.is_last;
                        r_s    <= (w_snr_raw > w_snr_cap) ? w_snr_cap : w_snr_raw;
                        r_j    <= 2'd0;
                        r_p    <= 2'd3;
                        r_acc  <= {{6{w_coef[43]}}, w_coef};
                        r_ssum <= 50'd1 << 24;
                        r_qi   <= 2'd0;
                        if (i_in_beat.is_last) begin
                            r_prev <= '0;
                            r_have <= 1'b0;
                        end else begin
                            r_prev <= i_in_beat.base_code;
                            r_have <= 1'b1;
                        end
                    end
                end
                S_HHI: begin
                    r_plo <= w_prod[36:0];
                end
                S_HADD: begin
                    r_acc <= w_hsum[57:8] + {{6{w_coef[43]}}, w_coef};
                    r_p   <= r_p - 2'd1;
                end
                S_CLAMP: begin
                    r_neg <= (r_acc < 0);
                end
                S_XDIV: begin
                    r_xq <= w_prod[68:48];
                end
                S_XFIX: begin
                    r_x <= r_neg ? -$signed({1'b0, w_xq}) : $signed({1'b0, w_xq});
                end
                S_YSET: begin
                    r_k <= w_prod[52:46];
                    r_f <= w_prod[45:30];
                end
                S_TSET: begin
                    r_t    <= w_prod[45:16];
                    r_term <= 31'd1 << 30;
                    r_sum  <= 31'd1 << 30;
                    r_n    <= 4'd1;
                end
                S_SACC: begin
                    r_term <= w_sterm;
                    r_sum  <= r_sum + w_sterm;
                    r_n    <= r_n + 4'd1;
                end
                S_ESET: begin
                    r_e[r_j] <= w_e;
                    r_ssum   <= r_ssum + {2'd0, w_e};
                    r_j      <= r_j + 2'd1;
                    r_p      <= 2'd3;
                    r_acc    <= {{6{w_coef[43]}}, w_coef};
                end
                S_QWAIT: begin
                    if (w_ddone) begin
                        r_q[r_qi] <= w_dq[15:0];
                        r_qi      <= r_qi + 2'd1;
                    end
                end
                S_ROW: begin
                    if (w_out_free) begin
                        r_out.position_base <= r_pos;
                        r_out.match_prob    <= r_q[0];
                        r_out.branch_prob   <= r_q[1];
                        r_out.stick_prob    <= r_q[2];
                        r_out.deletion_prob <= r_q[3];
                        r_out.row_last      <= 1'b0;
                    end
                end
                S_TERM: begin
                    if (w_out_free) begin
                        r_out.position_base <= r_curr;
                        r_out.match_prob    <= 16'd32768;
                        r_out.branch_prob   <= 16'd0;
                        r_out.stick_prob    <= 16'd0;
                        r_out.deletion_prob <= 16'd0;
                        r_out.row_last      <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end
endmodule
`default_nettype wire
